// File: sv/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;
  localparam int unsigned DEF_WIDTH = 32;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_SQR    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;
endpackage

// File: sv/modular_exponentiation_top.sv
// Top level of the modular exponentiation block.
// Usage: write the modulus on cfg_valid/cfg_data (cfg_ready is high while idle
// and start is low). Raise start with in_action, in_base, in_exponent while
// busy is low; the transfer happens at that edge. busy stays high until the
// result is out. out_valid is high for one cycle with out_result; the
// receiver cannot stall.
// Sequence: base reduction is one pass of the bit-serial multiplier
// (1 * base mod m), then for each exponent bit up to the highest set one
// a multiply (only when the bit is set) and a square, one pass apiece,
// then the DONE state raises out_valid. The next item is taken only after
// out_valid has fallen. The multiplier takes one multiplier bit per cycle.
// A zero exponent skips to DONE after the base reduction and answers 1.
// One item at a time. Reset makes modulus 1 and returns the block to idle.
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = modexp_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_action,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exponent,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIDTH-1:0] cfg_data
);
  import modexp_pkg::*;

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             ov_r, ov_nxt;
  logic             go;
  logic [WIDTH-1:0] mm_a, mm_b;
  logic             mm_done;
  logic [WIDTH-1:0] mm_p;
  logic [WIDTH-1:0] inv_exp;

  modexp_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(go), .a(mm_a), .b(mm_b), .m(mod_r),
    .done(mm_done), .p(mm_p)
  );

  always_comb begin
    if (mod_r == '0) inv_exp = {{(WIDTH-1){1'b1}}, 1'b0};
    else if (mod_r <= WIDTH'(2)) inv_exp = '0;
    else inv_exp = mod_r - WIDTH'(2);
  end

  always_comb begin
    state_nxt = state_r;
    mod_nxt   = mod_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    go        = 1'b0;
    mm_a      = base_r;
    mm_b      = base_r;
    if (cfg_valid && cfg_ready) mod_nxt = cfg_data;
    case (state_r)
      ST_IDLE: begin
        if (start && !ov_r) begin
          base_nxt  = in_base;
          exp_nxt   = in_action ? inv_exp : in_exponent;
          res_nxt   = WIDTH'(1);
          // reduce base: 1*base mod m, base shifted in as the multiplier
          mm_a      = WIDTH'(1);
          mm_b      = in_base;
          go        = 1'b1;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          base_nxt  = mm_p;
          state_nxt = ST_SQR;
          if (exp_r == '0) state_nxt = ST_DONE;
          else if (exp_r[0]) begin
            mm_a = res_r; mm_b = mm_p; go = 1'b1; state_nxt = ST_MUL;
          end else begin
            mm_a = mm_p; mm_b = mm_p; go = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          res_nxt = mm_p;
          mm_a = base_r; mm_b = base_r; go = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          base_nxt = mm_p;
          exp_nxt  = exp_r >> 1;
          if (exp_r[WIDTH-1:1] == '0) state_nxt = ST_DONE;
          else if (exp_r[1]) begin
            mm_a = res_r; mm_b = mm_p; go = 1'b1; state_nxt = ST_MUL;
          end else begin
            mm_a = mm_p; mm_b = mm_p; go = 1'b1;
          end
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= WIDTH'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
      ov_r    <= ov_nxt;
    end
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    res_r  <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE) || ov_r;
  assign cfg_ready  = (state_r == ST_IDLE) && !ov_r && !start;
  assign out_valid  = ov_r;
  assign out_result = res_r;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n) ov_r |=> !ov_r)
    else $error("result strobe longer than one cycle");
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> ov_r)
    else $error("finished item gave no result");
  a_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |=> $stable(mod_r))
    else $error("modulus changed during work");
endmodule

// File: sv/modexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module modexp_mulmod #(
  parameter int unsigned WIDTH = modexp_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] p
);
  import modexp_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   dbl, dbl_red, add, add_red;
  logic [WIDTH:0]   m_ext;

  // modulus zero means 2^WIDTH: plain wraparound
  always_comb begin
    m_ext   = (m == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, m};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    add     = dbl_red + {1'b0, a_r};
    add_red = (add >= m_ext) ? add - m_ext : add;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[WIDTH-1] ? add_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
